### rtl/ckgf_pkg.sv
// ----------------------------------------------------------------------------
// ckgf_pkg
// Shared types and constants for the chroma key gradient fill unit.
// ----------------------------------------------------------------------------
package ckgf_pkg;

    // channel and color widths
    localparam int CHAN_W   = 8;
    localparam int COLOR_W  = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_DIM_W  = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_COLOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_COLOR = 3'd4;

    // register reset values
    localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [COLOR_W-1:0]   KEY_COLOR_RST    = 24'hFF00FF;
    localparam logic [COLOR_W-1:0]   TOP_COLOR_RST    = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0]   BOTTOM_COLOR_RST = 24'hFFFFFF;

    // default largest frame dimension
    localparam int MAX_SIZE_DEF = 4096;

    // channel select codes for the gradient unit
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // top level sequencer
    typedef enum logic [1:0] {
        ST_RUN,
        ST_GRAD,
        ST_EMIT
    } top_state_t;

    // gradient unit sequencer
    typedef enum logic [1:0] {
        GS_IDLE,
        GS_MUL_BOT,
        GS_MUL_TOP,
        GS_DIV
    } grad_state_t;

    // gradient unit status
    typedef struct packed {
        logic busy;
        logic done;
    } grad_stat_t;

endpackage

### rtl/ckgf_stream_if.sv
// ----------------------------------------------------------------------------
// ckgf_stream_if
// Valid/ready pixel channels: incoming RGBA word and outgoing RGBA word.
// ----------------------------------------------------------------------------
interface ckgf_in_if;
    logic                        valid;
    logic                        ready;
    logic [ckgf_pkg::CHAN_W-1:0] red_in;
    logic [ckgf_pkg::CHAN_W-1:0] green_in;
    logic [ckgf_pkg::CHAN_W-1:0] blue_in;
    logic [ckgf_pkg::CHAN_W-1:0] alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface ckgf_out_if;
    logic                        valid;
    logic                        ready;
    logic [ckgf_pkg::CHAN_W-1:0] red_out;
    logic [ckgf_pkg::CHAN_W-1:0] green_out;
    logic [ckgf_pkg::CHAN_W-1:0] blue_out;
    logic [ckgf_pkg::CHAN_W-1:0] alpha_out;
    logic                        frame_last;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_last,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, frame_last,
                    output ready);
endinterface

### rtl/ckgf_grad_unit.sv
// ----------------------------------------------------------------------------
// ckgf_grad_unit
// Row gradient color: one shared multiplier and one compare/subtract stage,
// stepped per channel through a bottom multiply, a top multiply and a divide.
// ----------------------------------------------------------------------------
module ckgf_grad_unit #(
    parameter int DIM_W = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DIM_W-1:0]              row,
    input  logic [DIM_W-1:0]              height,
    input  logic [ckgf_pkg::COLOR_W-1:0]  top_color,
    input  logic [ckgf_pkg::COLOR_W-1:0]  bottom_color,
    output ckgf_pkg::grad_stat_t          stat,
    output logic [ckgf_pkg::COLOR_W-1:0]  color
);
    import ckgf_pkg::*;

    localparam int NUM_W = DIM_W + CHAN_W;

    grad_state_t          state_reg, state_next;
    logic [1:0]           chan_reg, chan_next;
    logic [2:0]           bit_reg, bit_next;
    logic                 done_reg, done_next;
    logic [DIM_W-1:0]     row_reg, row_next;
    logic [DIM_W-1:0]     h_reg, h_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [CHAN_W-1:0]    q_reg, q_next;
    logic [COLOR_W-1:0]   color_reg, color_next;

    logic [CHAN_W-1:0]    top_ch, bot_ch, mul_b;
    logic [DIM_W-1:0]     mul_a;
    logic [NUM_W-1:0]     prod, trial;
    logic                 ge;
    logic [CHAN_W-1:0]    q_new;

    // channel select
    always_comb
    begin
        case (chan_reg)
            CH_RED:
            begin
                top_ch = top_color[23:16];
                bot_ch = bottom_color[23:16];
            end
            CH_GREEN:
            begin
                top_ch = top_color[15:8];
                bot_ch = bottom_color[15:8];
            end
            default:
            begin
                top_ch = top_color[7:0];
                bot_ch = bottom_color[7:0];
            end
        endcase
    end

    // shared multiplier: row*bottom, then (h-row)*top
    assign mul_a = (state_reg == GS_MUL_BOT) ? row_reg : (h_reg - row_reg);
    assign mul_b = (state_reg == GS_MUL_BOT) ? bot_ch : top_ch;
    assign prod  = NUM_W'(mul_a) * NUM_W'(mul_b);

    // shared compare/subtract for one quotient bit
    assign trial = NUM_W'(h_reg) << bit_reg;
    assign ge    = (num_reg >= trial);
    assign q_new = {q_reg[CHAN_W-2:0], ge};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            GS_IDLE:
            begin
                if (start)
                    state_next = GS_MUL_BOT;
            end
            GS_MUL_BOT: state_next = GS_MUL_TOP;
            GS_MUL_TOP: state_next = GS_DIV;
            GS_DIV:
            begin
                if (bit_reg == 3'd0)
                    state_next = (chan_reg == CH_BLUE) ? GS_IDLE : GS_MUL_BOT;
            end
            default: state_next = GS_IDLE;
        endcase
    end

    // datapath and counters
    always_comb
    begin
        chan_next  = chan_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        row_next   = row_reg;
        h_next     = h_reg;
        num_next   = num_reg;
        q_next     = q_reg;
        color_next = color_reg;
        case (state_reg)
            GS_IDLE:
            begin
                if (start)
                begin
                    row_next  = row;
                    h_next    = height;
                    chan_next = CH_RED;
                end
            end
            GS_MUL_BOT:
            begin
                num_next = prod;
            end
            GS_MUL_TOP:
            begin
                num_next = num_reg + prod;
                bit_next = 3'd7;
            end
            GS_DIV:
            begin
                if (ge)
                    num_next = num_reg - trial;
                q_next   = q_new;
                bit_next = bit_reg - 3'd1;
                if (bit_reg == 3'd0)
                begin
                    case (chan_reg)
                        CH_RED:   color_next[23:16] = q_new;
                        CH_GREEN: color_next[15:8]  = q_new;
                        default:  color_next[7:0]   = q_new;
                    endcase
                    chan_next = chan_reg + 2'd1;
                    done_next = (chan_reg == CH_BLUE);
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= GS_IDLE;
            chan_reg  <= CH_RED;
            bit_reg   <= 3'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            bit_reg   <= bit_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        h_reg     <= h_next;
        num_reg   <= num_next;
        q_reg     <= q_next;
        color_reg <= color_next;
    end

    assign stat.busy = (state_reg != GS_IDLE);
    assign stat.done = done_reg;
    assign color     = color_reg;

    // a new row is only started while the unit is idle
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == GS_IDLE)
        else $error("gradient start while busy");

    // done follows the last divide step of the blue channel
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == GS_DIV && bit_reg == 3'd0 && chan_reg == CH_BLUE))
        else $error("gradient done without final divide step");

    // a bottom multiply is always followed by a top multiply
    a_mul_pair: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == GS_MUL_BOT |=> state_reg == GS_MUL_TOP)
        else $error("multiply sequence broken");

endmodule

### rtl/chroma_key_gradient_fill_unit.sv
// ----------------------------------------------------------------------------
// chroma_key_gradient_fill_unit
// Replaces key-colored RGB pixels with a per-row vertical gradient color.
//
//   channel   dir   handshake        payload
//   pix_in    in    valid / ready    red_in, green_in, blue_in, alpha_in
//   pix_out   out   valid / ready    red_out, green_out, blue_out, alpha_out,
//                                    frame_last
//   cfg       in    cfg_we           cfg_index, cfg_data
//
// A pixel that is not at column 0 goes straight to the output register; a new
// word is taken while the output register is drained in the same cycle.
// The first pixel of a row is held: the sequencer starts the shared multiply and
// divide unit, waits for its done after all three channels, then emits the word.
// Reset clears counters and control state and loads the register defaults.
// A stalled output holds its word; input is refused until it is taken.
// ----------------------------------------------------------------------------
module chroma_key_gradient_fill_unit #(
    parameter int MAX_SIZE = ckgf_pkg::MAX_SIZE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ckgf_in_if.sink                          pix_in,
    ckgf_out_if.source                       pix_out,
    input  logic                             cfg_we,
    input  logic [ckgf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ckgf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ckgf_pkg::*;

    localparam int EFF_W = $clog2(MAX_SIZE + 1);
    localparam int DIM_W = (EFF_W > CFG_DIM_W) ? EFF_W : CFG_DIM_W;
    localparam int CNT_W = $clog2(MAX_SIZE);
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_SIZE);
    localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);

    // configuration registers
    logic [CFG_DIM_W-1:0] width_reg, height_reg;
    logic [COLOR_W-1:0]   key_reg, top_reg, bottom_reg;

    // control
    top_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     col_reg, col_next;
    logic [CNT_W-1:0]     row_reg, row_next;
    logic                 out_valid_reg, out_valid_next;

    // payload
    logic [CHAN_W-1:0]    hold_r_reg, hold_g_reg, hold_b_reg, hold_a_reg;
    logic                 hold_last_reg;
    logic [CHAN_W-1:0]    out_r_reg, out_g_reg, out_b_reg, out_a_reg;
    logic                 out_last_reg;
    logic [CHAN_W-1:0]    out_r_next, out_g_next, out_b_next, out_a_next;
    logic                 out_last_next;

    logic [DIM_W-1:0]     w_eff, h_eff, col_ext, row_ext, grad_row;
    logic                 col_last, row_last, frame_last_now, col_zero;
    logic                 out_free, accept, in_ready, grad_start, out_load, emitting;
    logic [CHAN_W-1:0]    src_r, src_g, src_b, src_a;
    logic                 keyed;
    grad_stat_t           grad_stat;
    logic [COLOR_W-1:0]   grad_color;

    // clamp a dimension register to 1..MAX_SIZE
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
        logic [DIM_W-1:0] x;
        x = DIM_W'(v);
        if (x == '0)
            return DIM_ONE;
        else if (x > DIM_MAX)
            return DIM_MAX;
        else
            return x;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
            key_reg    <= KEY_COLOR_RST;
            top_reg    <= TOP_COLOR_RST;
            bottom_reg <= BOTTOM_COLOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[CFG_DIM_W-1:0];
                REG_KEY_COLOR:    key_reg    <= cfg_data[COLOR_W-1:0];
                REG_TOP_COLOR:    top_reg    <= cfg_data[COLOR_W-1:0];
                REG_BOTTOM_COLOR: bottom_reg <= cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // position flags
    assign w_eff          = clamp_dim(width_reg);
    assign h_eff          = clamp_dim(height_reg);
    assign col_ext        = DIM_W'(col_reg);
    assign row_ext        = DIM_W'(row_reg);
    assign col_last       = (col_ext >= w_eff - DIM_ONE);
    assign row_last       = (row_ext >= h_eff - DIM_ONE);
    assign frame_last_now = col_last && row_last;
    assign col_zero       = (col_reg == '0);
    assign grad_row       = row_last ? (h_eff - DIM_ONE) : row_ext;

    assign out_free = !out_valid_reg || pix_out.ready;
    assign accept   = in_ready && pix_in.valid;
    assign emitting = (state_reg == ST_EMIT);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (accept && col_zero)
                    state_next = ST_GRAD;
            end
            ST_GRAD:
            begin
                if (grad_stat.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready   = 1'b0;
        grad_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                in_ready   = out_free;
                grad_start = pix_in.valid && out_free && col_zero;
                out_load   = pix_in.valid && out_free && !col_zero;
            end
            ST_EMIT:
            begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    assign pix_in.ready = in_ready;

    // row gradient color
    ckgf_grad_unit #(
        .DIM_W (DIM_W)
    ) u_grad (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (grad_start),
        .row          (grad_row),
        .height       (h_eff),
        .top_color    (top_reg),
        .bottom_color (bottom_reg),
        .stat         (grad_stat),
        .color        (grad_color)
    );

    // counters advance on every accepted word
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    // key match and replacement
    assign src_r = emitting ? hold_r_reg : pix_in.red_in;
    assign src_g = emitting ? hold_g_reg : pix_in.green_in;
    assign src_b = emitting ? hold_b_reg : pix_in.blue_in;
    assign src_a = emitting ? hold_a_reg : pix_in.alpha_in;
    assign keyed = ({src_r, src_g, src_b} == key_reg);

    always_comb
    begin
        out_r_next    = keyed ? grad_color[23:16] : src_r;
        out_g_next    = keyed ? grad_color[15:8]  : src_g;
        out_b_next    = keyed ? grad_color[7:0]   : src_b;
        out_a_next    = src_a;
        out_last_next = emitting ? hold_last_reg : frame_last_now;
    end

    // output valid
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (pix_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // held word for the first pixel of a row
    always_ff @(posedge clk)
    begin
        if (grad_start)
        begin
            hold_r_reg    <= pix_in.red_in;
            hold_g_reg    <= pix_in.green_in;
            hold_b_reg    <= pix_in.blue_in;
            hold_a_reg    <= pix_in.alpha_in;
            hold_last_reg <= frame_last_now;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_r_reg    <= out_r_next;
            out_g_reg    <= out_g_next;
            out_b_reg    <= out_b_next;
            out_a_reg    <= out_a_next;
            out_last_reg <= out_last_next;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.red_out    = out_r_reg;
    assign pix_out.green_out  = out_g_reg;
    assign pix_out.blue_out   = out_b_reg;
    assign pix_out.alpha_out  = out_a_reg;
    assign pix_out.frame_last = out_last_reg;

    // gradient completes only while the sequencer waits for it
    a_done_in_grad: assert property (@(posedge clk) disable iff (!rst_n)
        grad_stat.done |-> state_reg == ST_GRAD)
        else $error("gradient done outside wait state");

    // while waiting, the gradient unit is working or just finished
    a_grad_alive: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GRAD |-> grad_stat.busy || grad_stat.done)
        else $error("waiting on an idle gradient unit");

    // a pending last word of the frame means the counters have wrapped
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && out_valid_reg && out_last_reg)
            |-> (col_reg == '0 && row_reg == '0))
        else $error("frame end without counter wrap");

endmodule
